### hw/rtl/crcbe_pkg.sv
// ----------------------------------------------------------------------------
// crcbe_pkg
// Shared types and constants for the byte-serial CRC-16 engine.
// ----------------------------------------------------------------------------
package crcbe_pkg;

   localparam int CRC_W  = 16;
   localparam int BYTE_W = 8;
   localparam int CSR_IDX_W = 2;
   localparam int KIND_W = 2;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_POLYNOMIAL    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_VALUE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_APPEND_ENABLE = 2'd2;

   localparam logic [CRC_W-1:0] POLY_RESET   = 16'h1021;
   localparam logic [CRC_W-1:0] INIT_RESET   = 16'hFFFF;
   localparam logic             APPEND_RESET = 1'b1;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_RUNNING   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TRAILER_0 = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TRAILER_1 = 2'd2;

   typedef struct packed {
      logic [CRC_W-1:0] polynomial;
      logic [CRC_W-1:0] init_value;
      logic             append_enable;
   } crcbe_cfg_type;

endpackage

### hw/rtl/crcbe_byte_absorb.sv
// ----------------------------------------------------------------------------
// crcbe_byte_absorb
// Absorbs one byte into a 16-bit CRC, LSB of the byte first, MSB feedback.
// ----------------------------------------------------------------------------
module crcbe_byte_absorb
   import crcbe_pkg::*;
(
   input  logic [CRC_W-1:0]  poly,
   input  logic [CRC_W-1:0]  crc_in,
   input  logic [BYTE_W-1:0] data_in,
   output logic [CRC_W-1:0]  crc_out
);

   logic [CRC_W-1:0] r;
   logic             fb;

   // eight unrolled shift steps
   always_comb begin
      r  = crc_in;
      fb = 1'b0;
      for (int k = 0; k < BYTE_W; k++) begin
         fb = r[CRC_W-1] ^ data_in[k];
         r  = {r[CRC_W-2:0], 1'b0} ^ (fb ? poly : {CRC_W{1'b0}});
      end
      crc_out = r;
   end

endmodule

### hw/rtl/crcbe_csr.sv
// ----------------------------------------------------------------------------
// crcbe_csr
// Configuration registers: polynomial, init value, trailer append enable.
// ----------------------------------------------------------------------------
module crcbe_csr
   import crcbe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CRC_W-1:0]     csr_wdata,
   output crcbe_cfg_type        cfg
);

   crcbe_cfg_type cfg_ff;
   crcbe_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_POLYNOMIAL:    cfg_in.polynomial    = csr_wdata;
            CSR_INIT_VALUE:    cfg_in.init_value    = csr_wdata;
            CSR_APPEND_ENABLE: cfg_in.append_enable = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.polynomial    <= POLY_RESET;
         cfg_ff.init_value    <= INIT_RESET;
         cfg_ff.append_enable <= APPEND_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/crcbe_rsp_stage.sv
// ----------------------------------------------------------------------------
// crcbe_rsp_stage
// Result register: finishes the check residue and plays out the running
// result plus the two trailer bytes when appending.
// ----------------------------------------------------------------------------
module crcbe_rsp_stage
   import crcbe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [CRC_W-1:0]   poly,
   input  logic               append_enable,
   input  logic               load_valid,
   input  logic [CRC_W-1:0]   load_crc,
   input  logic [CRC_W-1:0]   load_part,
   input  logic               load_end,
   output logic               free,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CRC_W-1:0]   rsp_crc_value,
   output logic [CRC_W-1:0]   rsp_check_residue,
   output logic [KIND_W-1:0]  rsp_out_kind,
   output logic [BYTE_W-1:0]  rsp_trailer_byte,
   output logic               rsp_last_result
);

   function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] x);
      logic [BYTE_W-1:0] r;
      for (int k = 0; k < BYTE_W; k++) begin
         r[k] = x[BYTE_W-1-k];
      end
      return r;
   endfunction

   logic               valid_ff;
   logic [KIND_W-1:0]  kind_ff;
   logic [CRC_W-1:0]   crc_ff;
   logic [CRC_W-1:0]   res_ff;
   logic               end_ff;
   logic               app_ff;
   logic [CRC_W-1:0]   res_in;
   logic [CRC_W-1:0]   inv;
   logic               fire;
   logic               done;
   logic               load;
   logic               final_item;

   // second residue byte: complemented high byte
   crcbe_byte_absorb u_res_hi (
      .poly    (poly),
      .crc_in  (load_part),
      .data_in (~load_crc[CRC_W-1:BYTE_W]),
      .crc_out (res_in)
   );

   // the register frees after the running result, or after the second
   // trailer when appending
   assign final_item      = app_ff ? (kind_ff == KIND_TRAILER_1) : 1'b1;
   assign inv             = ~crc_ff;
   assign rsp_last_result = app_ff ? (kind_ff == KIND_TRAILER_1) : end_ff;
   assign fire            = valid_ff & rsp_ready;
   assign done            = fire & final_item;
   assign free            = ~valid_ff | done;
   assign load            = load_valid & free;

   always_comb begin
      case (kind_ff)
         KIND_TRAILER_0: rsp_trailer_byte = rev8(inv[BYTE_W-1:0]);
         KIND_TRAILER_1: rsp_trailer_byte = rev8(inv[CRC_W-1:BYTE_W]);
         default:        rsp_trailer_byte = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         kind_ff  <= KIND_RUNNING;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            kind_ff  <= KIND_RUNNING;
         end else if (done) begin
            valid_ff <= 1'b0;
            kind_ff  <= KIND_RUNNING;
         end else if (fire) begin
            kind_ff  <= kind_ff + KIND_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         crc_ff <= load_crc;
         res_ff <= res_in;
         end_ff <= load_end;
         app_ff <= load_end & append_enable;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_crc_value     = crc_ff;
   assign rsp_check_residue = res_ff;
   assign rsp_out_kind      = kind_ff;

endmodule

### hw/rtl/crc16_byte_engine.sv
// ----------------------------------------------------------------------------
// crc16_byte_engine
// Byte-serial CRC-16 with programmable polynomial and init value.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one byte per item with frame_start / frame_end flags.
//   rsp_*  : one running result per byte (crc and check residue); with
//            append enabled, the last byte of a frame adds two trailer items.
//   csr_*  : write-only registers, written while the engine is idle.
// Path: a byte goes from req accept to the first rsp item through the CRC update,
//   the low residue byte, and the high residue byte into the result register.
// Throughput: one byte per cycle while rsp_ready is high and no trailer items
//   are pending; a byte that ends a frame with append holds the result register
//   for three rsp items. The CRC register loop is a mux plus eight feedback steps.
// Reset: CRC register goes to 0xFFFF, polynomial 0x1021, init 0xFFFF,
//   append on; pipeline empty.
// Stall: with rsp_ready low the result register holds; up to two more bytes are
//   taken into the internal stages before req_ready drops.
// ----------------------------------------------------------------------------
module crc16_byte_engine
   import crcbe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [BYTE_W-1:0]    req_data_byte,
   input  logic                 req_frame_start,
   input  logic                 req_frame_end,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CRC_W-1:0]     rsp_crc_value,
   output logic [CRC_W-1:0]     rsp_check_residue,
   output logic [KIND_W-1:0]    rsp_out_kind,
   output logic [BYTE_W-1:0]    rsp_trailer_byte,
   output logic                 rsp_last_result,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CRC_W-1:0]     csr_wdata
);

   crcbe_cfg_type    cfg;
   logic [CRC_W-1:0] crc_ff;
   logic [CRC_W-1:0] crc_in;
   logic [CRC_W-1:0] crc_base;
   logic             a_valid_ff;
   logic             a_end_ff;
   logic             b_valid_ff;
   logic [CRC_W-1:0] b_crc_ff;
   logic [CRC_W-1:0] b_part_ff;
   logic             b_end_ff;
   logic [CRC_W-1:0] part_in;
   logic             c_free;
   logic             b_free;
   logic             a_free;
   logic             accept;

   crcbe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign crc_base = req_frame_start ? cfg.init_value : crc_ff;

   crcbe_byte_absorb u_msg (
      .poly    (cfg.polynomial),
      .crc_in  (crc_base),
      .data_in (req_data_byte),
      .crc_out (crc_in)
   );

   // first residue byte: complemented low byte; crc_ff is stage A's crc
   crcbe_byte_absorb u_res_lo (
      .poly    (cfg.polynomial),
      .crc_in  (crc_ff),
      .data_in (~crc_ff[BYTE_W-1:0]),
      .crc_out (part_in)
   );

   assign b_free    = ~b_valid_ff | c_free;
   assign a_free    = ~a_valid_ff | b_free;
   assign req_ready = a_free;
   assign accept    = req_valid & a_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff     <= INIT_RESET;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            crc_ff <= crc_in;
         end
         if (a_free) begin
            a_valid_ff <= accept;
         end
         if (b_free) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_end_ff <= req_frame_end;
      end
      if (b_free) begin
         b_crc_ff  <= crc_ff;
         b_part_ff <= part_in;
         b_end_ff  <= a_end_ff;
      end
   end

   crcbe_rsp_stage u_rsp (
      .clock             (clock),
      .reset             (reset),
      .poly              (cfg.polynomial),
      .append_enable     (cfg.append_enable),
      .load_valid        (b_valid_ff),
      .load_crc          (b_crc_ff),
      .load_part         (b_part_ff),
      .load_end          (b_end_ff),
      .free              (c_free),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_crc_value     (rsp_crc_value),
      .rsp_check_residue (rsp_check_residue),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_trailer_byte  (rsp_trailer_byte),
      .rsp_last_result   (rsp_last_result)
   );

endmodule
